### rtl/glos_pkg.sv
// Shared constants, field widths and state codes for the grid line-of-sight block.
// No dependencies; imported by glos_div, grid_line_of_sight_dda and the bench.
package glos_pkg;

  localparam int COORD_W   = 6;
  localparam int GRID_W    = 64;
  localparam int GRID_H    = 64;
  localparam int ROW_AW    = $clog2(GRID_H);
  localparam int COL_AW    = $clog2(GRID_W);
  localparam int FRAC_BITS = 16;
  localparam int QUO_W     = COORD_W + FRAC_BITS;
  localparam int ACC_W     = QUO_W + 2;
  localparam int INT_W     = ACC_W - FRAC_BITS;
  localparam int DCNT_W    = $clog2(QUO_W);

  localparam int S_DATA_W  = 32;
  localparam int M_DATA_W  = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WR_RD  = 6'b000010,
    ST_WR_UPD = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_WALK   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_status_t;

endpackage

### rtl/glos_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module glos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/glos_div.sv
// Restoring unsigned divider, one quotient bit per cycle, for the line slope.
// Depends on glos_pkg.
module glos_div
  import glos_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [QUO_W-1:0]   dividend,
  input  logic [COORD_W-1:0] divisor,
  output div_status_t        status
);

  logic               active;
  logic [DCNT_W-1:0]  cnt;
  logic [COORD_W-1:0] rem;
  logic [QUO_W-1:0]   quo;
  logic [COORD_W-1:0] div_q;
  logic               done;

  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   diff;
  logic               ge;

  always_comb begin
    trial = {rem, quo[QUO_W-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == '0) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      div_q <= divisor;
      cnt   <= DCNT_W'(QUO_W - 1);
    end else if (active) begin
      rem <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign status.done     = done;
  assign status.quotient = quo;

endmodule

### rtl/grid_line_of_sight_dda.sv
// Line-of-sight over a 64x64 occupancy bitmap held as one 64-bit word per row.
// Write item: accept, row read, row write back; no result.
// Query item: setup, the slope divide, then one row read per visited cell
// (up to 63) plus drain and result; equal endpoints skip divide and walk.
// One item is in work at a time; a result still held on the output stalls
// the next query in its result cycle.
// Reset (rst, synchronous) clears the per-row valid bits, so all cells read clear.
// Depends on glos_pkg, glos_ram, glos_div.
module grid_line_of_sight_dda
  import glos_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [5:0] start_x, [11:6] start_y, [17:12] end_x, [23:18] end_y,
  // [24] cell_blocked, [31:25] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  // [0] cmd
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] line_clear, [7:1] zero
  output logic [M_DATA_W-1:0] m_tdata
);

  state_t state;

  logic [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
  logic               in_blk;
  logic               accept;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      adx, ady;
  logic                    in_xmaj;
  logic                    same_pt;

  // write path
  logic [ROW_AW-1:0] wr_row;
  logic [COL_AW-1:0] wr_col;
  logic              wr_blk;

  // walk state
  logic                    x_major;
  logic                    step_neg;
  logic                    slope_neg;
  logic [COORD_W-1:0]      maj;
  logic [COORD_W-1:0]      left;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] slope;
  logic                    blocked;
  logic                    pend;
  logic                    pend_ok;
  logic [COL_AW-1:0]       pend_col;

  logic [INT_W-1:0]  minor_int;
  logic              minor_ok;
  logic [ROW_AW-1:0] issue_row;
  logic [COL_AW-1:0] issue_col;
  logic              hit;

  logic [GRID_H-1:0] row_valid;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_raddr;
  logic [GRID_W-1:0] ram_wdata;
  logic [GRID_W-1:0] ram_rdata;
  logic [GRID_W-1:0] old_row;

  logic               div_start;
  logic [QUO_W-1:0]   div_dividend;
  logic [COORD_W-1:0] div_divisor;
  div_status_t        div_st;
  logic [ACC_W-1:0]   quo_ext;

  logic line_clear;

  assign in_sx  = s_tdata[COORD_W-1:0];
  assign in_sy  = s_tdata[2*COORD_W-1:COORD_W];
  assign in_ex  = s_tdata[3*COORD_W-1:2*COORD_W];
  assign in_ey  = s_tdata[4*COORD_W-1:3*COORD_W];
  assign in_blk = s_tdata[4*COORD_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    dx      = $signed({1'b0, in_ex}) - $signed({1'b0, in_sx});
    dy      = $signed({1'b0, in_ey}) - $signed({1'b0, in_sy});
    adx     = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady     = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    in_xmaj = adx > ady;
    same_pt = (in_sx == in_ex) && (in_sy == in_ey);
  end

  assign div_start    = accept && (s_tuser == CMD_QUERY) && !same_pt;
  assign div_dividend = {(in_xmaj ? ady : adx), {FRAC_BITS{1'b0}}};
  assign div_divisor  = in_xmaj ? adx : ady;

  glos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st)
  );

  assign quo_ext = {2'b00, div_st.quotient};

  // floor of the accumulator; the cell is on the grid when it lies in 0..63
  always_comb begin
    minor_int = acc[ACC_W-1:FRAC_BITS];
    minor_ok  = (minor_int[INT_W-1:COORD_W] == '0);
    issue_row = x_major ? minor_int[ROW_AW-1:0] : maj;
    issue_col = x_major ? maj : minor_int[COL_AW-1:0];
    hit       = pend && pend_ok && ram_rdata[pend_col];
  end

  always_comb begin
    ram_raddr = (state == ST_WALK) ? issue_row : wr_row;
    ram_we    = (state == ST_WR_UPD);
    old_row   = row_valid[wr_row] ? ram_rdata : '0;
    ram_wdata = old_row;
    ram_wdata[wr_col] = wr_blk;
  end

  glos_ram #(
    .WIDTH (GRID_W),
    .DEPTH (GRID_H)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_row),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      m_tvalid  <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // the result cycle reloads the output itself
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == CMD_WRITE) begin
              state <= ST_WR_RD;
            end else if (same_pt) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_WR_RD: begin
          state <= ST_WR_UPD;
        end
        ST_WR_UPD: begin
          row_valid[wr_row] <= 1'b1;
          state             <= ST_IDLE;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          pend <= (left != '0) && !hit;
          if (hit || (left == '0 && !pend)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_row    <= in_sy[ROW_AW-1:0];
      wr_col    <= in_sx[COL_AW-1:0];
      wr_blk    <= in_blk;
      x_major   <= in_xmaj;
      step_neg  <= in_xmaj ? dx[COORD_W] : dy[COORD_W];
      slope_neg <= dx[COORD_W] ^ dy[COORD_W];
      maj       <= in_xmaj ? in_sx : in_sy;
      left      <= in_xmaj ? adx : ady;
      acc       <= {2'b00, (in_xmaj ? in_sy : in_sx), {FRAC_BITS{1'b0}}};
      blocked   <= 1'b0;
    end
    if (state == ST_DIV && div_st.done) begin
      slope <= slope_neg ? -$signed(quo_ext) : $signed(quo_ext);
    end
    if (state == ST_WALK) begin
      if (hit) begin
        blocked <= 1'b1;
      end
      if (left != '0) begin
        pend_col <= issue_col;
        pend_ok  <= minor_ok && row_valid[issue_row];
        maj      <= step_neg ? maj - 1'b1 : maj + 1'b1;
        acc      <= acc + slope;
        left     <= left - 1'b1;
      end
    end
    if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      line_clear <= !blocked;
    end
  end

  assign m_tdata = {{(M_DATA_W-1){1'b0}}, line_clear};

endmodule

### tb/tb.sv
// Self-checking bench for grid_line_of_sight_dda: cell writes and line queries over the
// occupancy map, with results predicted by an in-bench DDA walk and checked in order.
// Depends on glos_pkg and the grid_line_of_sight_dda RTL.
module tb;
  import glos_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

  typedef struct {
    logic              cmd;
    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic              blk;
    idle_phase_t       phase;
    bit                hold;
  } grid_item_t;

  typedef struct {
    logic              clear;
    logic [COORD_W-1:0] sx, sy, ex, ey;
  } sight_answer_t;

  localparam int WD_LIMIT     = 5000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_ITEMS  = 450;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  grid_item_t    pending_items[$];
  grid_item_t    in_flight;
  sight_answer_t clear_expected[$];
  bit            occ_map [GRID_H][GRID_W];

  idle_phase_t fill_phase = PH_NONE;
  bit          fill_hold = 1'b0;
  int          mismatches = 0;
  int          writes_done = 0;
  int          queries_done = 0;
  int          clear_seen = 0;
  int          blocked_seen = 0;
  int          stall_cycles = 0;

  grid_line_of_sight_dda uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit cell_set(int x, int y);
    if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) return 1'b0;
    return occ_map[y][x];
  endfunction

  // DDA walk: major axis from start up to, not including, end; minor axis is a
  // FRAC_BITS fixed-point accumulator read with a floor shift.
  function automatic bit sight_line_clear(int x0, int y0, int x1, int y1);
    int     dx, dy, adx, ady, step, k;
    longint slope, acc;
    dx  = x1 - x0;
    dy  = y1 - y0;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    if (dx == 0 && dy == 0) return 1'b1;
    if (adx > ady) begin
      slope = (longint'(dy) * (longint'(1) << FRAC_BITS)) / longint'(dx);
      acc   = longint'(y0) << FRAC_BITS;
      step  = dx > 0 ? 1 : -1;
      for (k = x0; k != x1; k += step) begin
        if (cell_set(k, int'(acc >>> FRAC_BITS))) return 1'b0;
        acc += slope;
      end
    end else begin
      slope = (longint'(dx) * (longint'(1) << FRAC_BITS)) / longint'(dy);
      acc   = longint'(x0) << FRAC_BITS;
      step  = dy > 0 ? 1 : -1;
      for (k = y0; k != y1; k += step) begin
        if (cell_set(int'(acc >>> FRAC_BITS), k)) return 1'b0;
        acc += slope;
      end
    end
    return 1'b1;
  endfunction

  task automatic record_accepted(grid_item_t it);
    sight_answer_t ans;
    if (it.cmd == CMD_WRITE) begin
      occ_map[it.sy][it.sx] = it.blk;
      writes_done++;
    end else begin
      ans.clear = sight_line_clear(it.sx, it.sy, it.ex, it.ey);
      ans.sx = it.sx;
      ans.sy = it.sy;
      ans.ex = it.ex;
      ans.ey = it.ey;
      clear_expected.push_back(ans);
      queries_done++;
    end
  endtask

  function automatic bit idle_roll(idle_phase_t ph, bit rx_side);
    case (ph)
      PH_SEND: return !rx_side && ($urandom_range(0, 99) < 74);
      PH_RECV: return rx_side && ($urandom_range(0, 99) < 74);
      PH_BOTH: return $urandom_range(0, 99) < 20;
      default: return 1'b0;
    endcase
  endfunction

  // Driver: one item held on the bus until accepted, then the next one loaded.
  always @(posedge clk) begin
    bit can_load;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      can_load = !s_tvalid;
      if (s_tvalid && s_tready) begin
        record_accepted(in_flight);
        can_load = 1'b1;
      end
      if (can_load) begin
        if (pending_items.size() > 0 &&
            !(pending_items[0].hold && clear_expected.size() > 0) &&
            !idle_roll(pending_items[0].phase, 1'b0)) begin
          in_flight = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'b0, in_flight.blk, in_flight.ey, in_flight.ex,
                       in_flight.sy, in_flight.sx};
          s_tuser  <= in_flight.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest predicted answer.
  always @(posedge clk) begin
    sight_answer_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (clear_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result tdata=%h at %0t", m_tdata, $realtime);
        end else begin
          want = clear_expected.pop_front();
          if (m_tdata !== {7'b0, want.clear}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("line (%0d,%0d)->(%0d,%0d): expected line_clear=%0b got tdata=%h",
                       want.sx, want.sy, want.ex, want.ey, want.clear, m_tdata);
          end
          if (want.clear) clear_seen++;
          else blocked_seen++;
        end
      end
      m_tready <= !idle_roll(in_flight.phase, 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WD_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WD_LIMIT);
        $display("FAIL grid_line_of_sight_dda");
        $finish;
      end
    end
  end

  task automatic add_item(logic cmd, int sx, int sy, int ex, int ey, logic blk);
    grid_item_t it;
    it.cmd   = cmd;
    it.sx    = sx[COORD_W-1:0];
    it.sy    = sy[COORD_W-1:0];
    it.ex    = ex[COORD_W-1:0];
    it.ey    = ey[COORD_W-1:0];
    it.blk   = blk;
    it.phase = fill_phase;
    it.hold  = fill_hold;
    fill_hold = 1'b0;
    pending_items.push_back(it);
  endtask

  function automatic int near_coord(int c);
    int v;
    v = c + $urandom_range(0, 16) - 8;
    if (v < 0) v = 0;
    if (v > GRID_W - 1) v = GRID_W - 1;
    return v;
  endfunction

  // Short lines (half of the queries, often clear) mixed with long ones, axis-aligned and
  // zero-length lines, and writes that set about a third of the touched cells.
  task automatic add_random_items(int n);
    int k, r, sx, sy, ex, ey;
    for (k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      sx = $urandom_range(0, GRID_W - 1);
      sy = $urandom_range(0, GRID_H - 1);
      ex = $urandom_range(0, GRID_W - 1);
      ey = $urandom_range(0, GRID_H - 1);
      if (r < 40) begin
        add_item(CMD_WRITE, sx, sy, ex, ey, $urandom_range(0, 99) < 35);
      end else begin
        if (r < 45) begin
          ex = sx;
          ey = sy;
        end else if (r < 50) begin
          if (r[0]) ex = sx;
          else ey = sy;
        end else if (r < 80) begin
          ex = near_coord(sx);
          ey = near_coord(sy);
        end
        add_item(CMD_QUERY, sx, sy, ex, ey, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    // corners and diagonals on an empty map
    add_item(CMD_QUERY, 0, 0, 63, 63, 1'b1);
    add_item(CMD_QUERY, 63, 0, 0, 63, 1'b0);
    add_item(CMD_WRITE, 0, 0, 63, 63, 1'b1);
    add_item(CMD_WRITE, 63, 63, 0, 0, 1'b1);
    add_item(CMD_WRITE, 63, 0, 0, 0, 1'b1);
    add_item(CMD_WRITE, 0, 63, 0, 0, 1'b1);
    add_item(CMD_WRITE, 20, 30, 0, 0, 1'b1);
    // equal endpoints answer clear even on an occupied cell
    add_item(CMD_QUERY, 0, 0, 0, 0, 1'b0);
    add_item(CMD_QUERY, 0, 0, 63, 63, 1'b0);
    add_item(CMD_QUERY, 63, 63, 0, 0, 1'b0);
    // occupied end cells are not visited
    add_item(CMD_QUERY, 1, 1, 63, 63, 1'b0);
    add_item(CMD_QUERY, 62, 0, 0, 0, 1'b0);
    add_item(CMD_QUERY, 0, 1, 0, 63, 1'b0);
    // x major and y major, both directions, through the cell at (20,30)
    add_item(CMD_QUERY, 10, 25, 30, 35, 1'b0);
    add_item(CMD_QUERY, 30, 35, 10, 25, 1'b0);
    add_item(CMD_QUERY, 25, 10, 15, 50, 1'b0);
    // negative steps on the major axis, and a negative slope that truncates toward zero
    add_item(CMD_QUERY, 40, 63, 0, 0, 1'b0);
    add_item(CMD_QUERY, 5, 0, 0, 63, 1'b0);
    add_item(CMD_WRITE, 20, 30, 63, 63, 1'b0);
    add_item(CMD_QUERY, 10, 25, 30, 35, 1'b0);
    add_item(CMD_QUERY, 63, 62, 0, 1, 1'b0);
    // equal delta magnitudes take y as major
    add_item(CMD_QUERY, 10, 10, 20, 20, 1'b0);
    add_item(CMD_QUERY, 50, 10, 10, 50, 1'b0);
    add_random_items(PHASE_ITEMS);
    fill_phase = PH_SEND;
    fill_hold  = 1'b1;
    add_random_items(PHASE_ITEMS);
    fill_phase = PH_RECV;
    fill_hold  = 1'b1;
    add_random_items(PHASE_ITEMS);
    fill_phase = PH_BOTH;
    fill_hold  = 1'b1;
    add_random_items(PHASE_ITEMS);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() > 0 || s_tvalid || clear_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (clear_expected.size() > 0) begin
      mismatches += clear_expected.size();
      $display("%0d line results never arrived", clear_expected.size());
    end
    $display("run: %0d cell writes, %0d line queries (%0d clear, %0d blocked)",
             writes_done, queries_done, clear_seen, blocked_seen);
    $display("idle phases: none, sender, receiver, both; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS grid_line_of_sight_dda");
    end else begin
      $display("FAIL grid_line_of_sight_dda");
    end
    $finish;
  end

endmodule
